/* rtl/ple_pkg.sv */
`default_nettype none

package ple_pkg;

    // default number of list cells
    localparam int CAPACITY_DEF = 32;

    // field widths
    localparam int ACTION_W   = 2;
    localparam int POSITION_W = 6;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 6;

    // packed stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOPOS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

endpackage

`default_nettype wire

/* rtl/ple_store.sv */
`default_nettype none

module ple_store #(
    parameter int DEPTH = ple_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(ple_pkg::CAPACITY_DEF)
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [ple_pkg::VALUE_W-1:0]   wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [ple_pkg::VALUE_W-1:0]   rd_data
);
    import ple_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/positional_list_engine_top.sv */
// channel   dir   fields (lowest bit first)
// s_*       in    tuser: action[1:0]; tdata: position[5:0], value[37:6]
// m_*       out   tuser: has_value; tdata: status[1:0], element[33:2], count[39:34];
//                 tlast: last
//
// an item is taken only when the engine is idle; the output register lets the
// next item in while the previous result waits
// a shifting insert or delete moves count - position + 1 or count - position cells,
// the one-read one-write cell memory moving one cell per cycle
// read-out: elements back to back while m_tready stays high
// reset clears the registers only; cells beyond the count are never read
`default_nettype none

module positional_list_engine_top #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ple_pkg::S_TDATA_W-1:0]   s_tdata,   // position, value
    input  wire logic [ple_pkg::ACTION_W-1:0]    s_tuser,   // action
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [ple_pkg::M_TDATA_W-1:0]   m_tdata,   // status, element, count
    output logic                                 m_tuser,   // has_value
    output logic                                 m_tlast
);
    import ple_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int XW    = ((CNT_W > POSITION_W) ? CNT_W : POSITION_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_FINISH,
        S_READ
    } state_t;

    state_t               state_reg, state_next;
    logic [ACTION_W-1:0]  act_reg, act_next;
    logic [POSITION_W-1:0] pos_reg, pos_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic [STATUS_W-1:0]  fin_status_reg, fin_status_next;
    logic                 fin_wr_reg, fin_wr_next;
    logic                 fin_inc_reg, fin_inc_next;
    logic                 fin_dec_reg, fin_dec_next;
    logic [AW-1:0]        fin_addr_reg, fin_addr_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic                 m_has_reg, m_has_next;
    logic [VALUE_W-1:0]   m_elem_reg, m_elem_next;
    logic [COUNT_W-1:0]   m_count_reg, m_count_next;
    logic                 m_last_reg, m_last_next;

    logic                 mem_wr, mem_rd;
    logic [AW-1:0]        mem_wr_addr, mem_rd_addr;
    logic [VALUE_W-1:0]   mem_wr_data, mem_rd_data;

    logic                 m_free;
    logic [XW-1:0]        cnt_x, pos_x, cnt_after;

    ple_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_free = !m_valid_reg || m_tready;
    assign cnt_x  = XW'(count_reg);
    assign pos_x  = XW'(pos_reg);

    // count after the pending insert or delete
    always_comb
    begin
        cnt_after = cnt_x;
        if (fin_inc_reg)
        begin
            cnt_after = cnt_x + XW'(1);
        end
        else if (fin_dec_reg)
        begin
            cnt_after = cnt_x - XW'(1);
        end
    end

    // next-state and memory control
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        fin_status_next = fin_status_reg;
        fin_wr_next     = fin_wr_reg;
        fin_inc_next    = fin_inc_reg;
        fin_dec_next    = fin_dec_reg;
        fin_addr_next   = fin_addr_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_has_next      = m_has_reg;
        m_elem_next     = m_elem_reg;
        m_count_next    = m_count_reg;
        m_last_next     = m_last_reg;
        mem_wr          = 1'b0;
        mem_wr_addr     = '0;
        mem_wr_data     = '0;
        mem_rd          = 1'b0;
        mem_rd_addr     = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next   = s_tuser;
                    pos_next   = s_tdata[POSITION_W-1:0];
                    val_next   = s_tdata[POSITION_W +: VALUE_W];
                    state_next = S_EXEC;
                end
            end

            // decide the outcome and set up the cell moves
            S_EXEC:
            begin
                fin_status_next = STAT_OK;
                fin_wr_next     = 1'b0;
                fin_inc_next    = 1'b0;
                fin_dec_next    = 1'b0;
                fin_addr_next   = '0;
                pend_next       = 1'b0;
                state_next      = S_FINISH;
                case (act_reg)
                    ACT_INSERT:
                    begin
                        if (cnt_x >= XW'(CAPACITY))
                        begin
                            fin_status_next = STAT_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            fin_wr_next  = 1'b1;
                            fin_inc_next = 1'b1;
                        end
                        else if (pos_reg == '0 || pos_x > cnt_x + XW'(1))
                        begin
                            fin_status_next = STAT_NOPOS;
                        end
                        else
                        begin
                            fin_wr_next   = 1'b1;
                            fin_inc_next  = 1'b1;
                            fin_addr_next = AW'(pos_x - XW'(1));
                            rem_next      = CNT_W'(cnt_x - pos_x + XW'(1));
                            ptr_next      = AW'(cnt_x - XW'(1));
                            state_next    = S_SHIFT;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            fin_status_next = STAT_EMPTY;
                        end
                        else if (pos_reg == '0 || pos_x > cnt_x)
                        begin
                            fin_status_next = STAT_NOPOS;
                        end
                        else
                        begin
                            fin_dec_next = 1'b1;
                            rem_next     = CNT_W'(cnt_x - pos_x);
                            ptr_next     = AW'(pos_x);
                            state_next   = S_SHIFT;
                        end
                    end
                    ACT_READ:
                    begin
                        if (count_reg != '0)
                        begin
                            mem_rd      = 1'b1;
                            mem_rd_addr = '0;
                            ptr_next    = '0;
                            state_next  = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // move one cell per cycle: read ahead, write the previous read
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_wr      = 1'b1;
                    mem_wr_data = mem_rd_data;
                    if (act_reg == ACT_INSERT)
                    begin
                        mem_wr_addr = pend_addr_reg + AW'(1);
                    end
                    else
                    begin
                        mem_wr_addr = pend_addr_reg - AW'(1);
                    end
                end
                if (rem_reg != '0)
                begin
                    mem_rd         = 1'b1;
                    mem_rd_addr    = ptr_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                    rem_next       = rem_reg - CNT_W'(1);
                    if (act_reg == ACT_INSERT)
                    begin
                        ptr_next = ptr_reg - AW'(1);
                    end
                    else
                    begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
                else
                begin
                    // last pending write lands this cycle
                    pend_next  = 1'b0;
                    state_next = S_FINISH;
                end
            end

            // single status result, commit value and count
            S_FINISH:
            begin
                if (m_free)
                begin
                    if (fin_wr_reg)
                    begin
                        mem_wr      = 1'b1;
                        mem_wr_addr = fin_addr_reg;
                        mem_wr_data = val_reg;
                    end
                    count_next    = CNT_W'(cnt_after);
                    m_valid_next  = 1'b1;
                    m_status_next = fin_status_reg;
                    m_has_next    = 1'b0;
                    m_elem_next   = '0;
                    m_count_next  = COUNT_W'(cnt_after);
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            // stream out cells, next read issued with each transfer
            S_READ:
            begin
                if (m_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_has_next    = 1'b1;
                    m_elem_next   = mem_rd_data;
                    m_count_next  = COUNT_W'(count_reg);
                    if (XW'(ptr_reg) + XW'(1) == cnt_x)
                    begin
                        m_last_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        m_last_next = 1'b0;
                        mem_rd      = 1'b1;
                        mem_rd_addr = ptr_reg + AW'(1);
                        ptr_next    = ptr_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= '0;
            pos_reg        <= '0;
            val_reg        <= '0;
            count_reg      <= '0;
            rem_reg        <= '0;
            ptr_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            fin_status_reg <= '0;
            fin_wr_reg     <= 1'b0;
            fin_inc_reg    <= 1'b0;
            fin_dec_reg    <= 1'b0;
            fin_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
            m_status_reg   <= '0;
            m_has_reg      <= 1'b0;
            m_elem_reg     <= '0;
            m_count_reg    <= '0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            act_reg        <= act_next;
            pos_reg        <= pos_next;
            val_reg        <= val_next;
            count_reg      <= count_next;
            rem_reg        <= rem_next;
            ptr_reg        <= ptr_next;
            pend_reg       <= pend_next;
            pend_addr_reg  <= pend_addr_next;
            fin_status_reg <= fin_status_next;
            fin_wr_reg     <= fin_wr_next;
            fin_inc_reg    <= fin_inc_next;
            fin_dec_reg    <= fin_dec_next;
            fin_addr_reg   <= fin_addr_next;
            m_valid_reg    <= m_valid_next;
            m_status_reg   <= m_status_next;
            m_has_reg      <= m_has_next;
            m_elem_reg     <= m_elem_next;
            m_count_reg    <= m_count_next;
            m_last_reg     <= m_last_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_elem_reg, m_status_reg};
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

/* rtl/ple_checker.sv */
`default_nettype none

module ple_checker #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [ple_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [ple_pkg::ACTION_W-1:0]    s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [ple_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                            m_tuser,
    input  wire logic                            m_tlast
);
    import ple_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // one item in flight: no transfer right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // elements come only with ok status
    a_elem_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[1:0] == STAT_OK)
        else $error("element with error status");

    // status-only results close their item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("status result without last");

    // reported count never exceeds capacity
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[39:34]) <= CAPACITY)
        else $error("count above capacity");

endmodule

bind positional_list_engine_top ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

`default_nettype wire

/* verif/positional_list_engine_top_tb.sv */
`default_nettype none

module positional_list_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ple_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                has_value;
        logic [VALUE_W-1:0]  element;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } list_result_t;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [POSITION_W-1:0] position;
        logic [VALUE_W-1:0]    value;
        logic                  typed;
        logic [STATUS_W-1:0]   want_status;
    } list_cmd_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [ACTION_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    positional_list_engine_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // shadow list state
    logic [VALUE_W-1:0] shadow_cells [CAP];
    int                 shadow_len;
    list_result_t       pending_results [$];
    bit                 failed;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 hold_recv;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic list_result_t make_result(logic [STATUS_W-1:0] st, logic hv,
                                                 logic [VALUE_W-1:0] el, logic lst);
        list_result_t r;
        r.status    = st;
        r.has_value = hv;
        r.element   = el;
        r.count     = COUNT_W'(shadow_len);
        r.last      = lst;
        return r;
    endfunction

    // apply one command to the shadow list and queue what it should produce
    function automatic logic [STATUS_W-1:0] apply_list_cmd(logic [ACTION_W-1:0] act,
                                                          logic [POSITION_W-1:0] pos,
                                                          logic [VALUE_W-1:0] val);
        logic [STATUS_W-1:0] st;
        int p;
        st = STAT_OK;
        p  = pos;
        if (act == ACT_INSERT)
        begin
            if (shadow_len >= CAP)
                st = STAT_FULL;
            else if (shadow_len == 0)
            begin
                shadow_cells[0] = val;
                shadow_len = 1;
            end
            else if (p < 1 || p > shadow_len + 1)
                st = STAT_NOPOS;
            else
            begin
                for (int i = shadow_len; i > p - 1; i--)
                    shadow_cells[i] = shadow_cells[i-1];
                shadow_cells[p-1] = val;
                shadow_len++;
            end
            pending_results.push_back(make_result(st, 1'b0, '0, 1'b1));
        end
        else if (act == ACT_DELETE)
        begin
            if (shadow_len == 0)
                st = STAT_EMPTY;
            else if (p < 1 || p > shadow_len)
                st = STAT_NOPOS;
            else
            begin
                for (int i = p - 1; i + 1 < shadow_len; i++)
                    shadow_cells[i] = shadow_cells[i+1];
                shadow_len--;
            end
            pending_results.push_back(make_result(st, 1'b0, '0, 1'b1));
        end
        else if (act == ACT_READ && shadow_len > 0)
        begin
            for (int i = 0; i < shadow_len; i++)
                pending_results.push_back(make_result(STAT_OK, 1'b1, shadow_cells[i],
                                                      i + 1 == shadow_len));
        end
        else
            pending_results.push_back(make_result(STAT_OK, 1'b0, '0, 1'b1));
        return st;
    endfunction

    // offer one transfer with random idle gap, then update the shadow list
    task automatic send_cmd(input list_cmd_t c);
        logic [STATUS_W-1:0] st;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.action;
        s_tdata  <= {c.value, c.position};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        st = apply_list_cmd(c.action, c.position, c.value);
        if (c.typed && st != c.want_status)
        begin
            $error("directed status expected %0d actual %0d", c.want_status, st);
            failed = 1'b1;
        end
    endtask

    function automatic list_cmd_t cmd(logic [ACTION_W-1:0] a, int p, logic [VALUE_W-1:0] v,
                                      bit t = 0, logic [STATUS_W-1:0] s = STAT_OK);
        list_cmd_t c;
        c.action = a;
        c.position = POSITION_W'(p);
        c.value = v;
        c.typed = t;
        c.want_status = s;
        return c;
    endfunction

    // receiver side: random stall plus long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end

    // result checking
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status    = m_tdata[1:0];
            got.element   = m_tdata[33:2];
            got.count     = m_tdata[39:34];
            got.has_value = m_tuser;
            got.last      = m_tlast;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer");
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    failed = 1'b1;
                end
                if (got.has_value != want.has_value)
                begin
                    $error("has_value expected %0d actual %0d", want.has_value,
                           got.has_value);
                    failed = 1'b1;
                end
                if (got.element != want.element)
                begin
                    $error("element expected %0h actual %0h", want.element, got.element);
                    failed = 1'b1;
                end
                if (got.count != want.count)
                begin
                    $error("count expected %0d actual %0d", want.count, got.count);
                    failed = 1'b1;
                end
                if (got.last != want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, got.last);
                    failed = 1'b1;
                end
            end
        end
    end

    // random command biased toward well-formed positions
    function automatic list_cmd_t random_cmd();
        int r;
        int p;
        r = $urandom_range(99);
        if ($urandom_range(9) < 8)
            p = $urandom_range(shadow_len + 1, 1);
        else
            p = $urandom_range(63);
        if (r < 55)
            return cmd(ACT_INSERT, p, $urandom);
        else if (r < 88)
            return cmd(ACT_DELETE, p, $urandom);
        else if (r < 97)
            return cmd(ACT_READ, $urandom_range(63), $urandom);
        return cmd(2'd3, $urandom_range(63), $urandom);
    endfunction

    list_cmd_t directed_rows [$];

    initial
    begin
        int k;
        failed = 1'b0;
        shadow_len = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, every action
        directed_rows = '{
            cmd(ACT_READ,   0, '0),
            cmd(ACT_DELETE, 1, '0, 1, STAT_EMPTY),
            cmd(ACT_INSERT, 0, 32'h8000_0000, 1, STAT_OK),
            cmd(ACT_INSERT, 0, 32'h1234_5678, 1, STAT_NOPOS),
            cmd(ACT_INSERT, 3, 32'h1234_5678, 1, STAT_NOPOS),
            cmd(ACT_INSERT, 2, 32'h7fff_ffff, 1, STAT_OK),
            cmd(ACT_INSERT, 1, 32'hffff_ffff, 1, STAT_OK),
            cmd(ACT_INSERT, 2, 32'h0000_0000, 1, STAT_OK),
            cmd(ACT_READ,  63, 32'hffff_ffff),
            cmd(ACT_DELETE, 0, '0, 1, STAT_NOPOS),
            cmd(ACT_DELETE, 5, '0, 1, STAT_NOPOS),
            cmd(ACT_DELETE, 63, '0, 1, STAT_NOPOS),
            cmd(ACT_DELETE, 4, '0, 1, STAT_OK),
            cmd(ACT_DELETE, 1, '0, 1, STAT_OK),
            cmd(2'd3,      63, 32'hffff_ffff),
            cmd(ACT_READ,   0, '0)
        };
        foreach (directed_rows[i])
            send_cmd(directed_rows[i]);

        // fill to capacity, then two inserts into the full list
        while (shadow_len < CAP)
            send_cmd(cmd(ACT_INSERT, $urandom_range(shadow_len + 1, 1), $urandom));
        send_cmd(cmd(ACT_INSERT, 1, 32'h5555_aaaa, 1, STAT_FULL));
        send_cmd(cmd(ACT_INSERT, 63, 32'h5555_aaaa, 1, STAT_FULL));

        // long receiver hold-off while the sender keeps offering
        hold_recv = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_recv = 1'b0;
            end
            begin
                send_cmd(cmd(ACT_READ, 0, '0));
                for (int j = 0; j < 8; j++)
                    send_cmd(cmd(ACT_DELETE, 1, '0));
            end
        join

        // random phases of idling
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (k = 0; k < 100; k++)
                send_cmd(random_cmd());
        end
        s_tvalid <= 1'b0;

        // drain
        k = 0;
        while (pending_results.size() != 0 && k < 100000)
        begin
            @(posedge clk);
            k++;
        end
        repeat (100) @(posedge clk);
        if (pending_results.size() != 0)
            failed = 1'b1;
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
